FILE: hw/rtl/deq_pkg.sv
// Package for the double-ended queue: field widths, command and status codes,
// default parameter values and the controller-to-datapath command type.
// No dependencies.
`default_nettype none
package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  localparam logic [CMD_W-1:0] CMD_ADD_FRONT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_BACK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;      // execute the incoming request this cycle
    logic load_out;  // load the result register
  } deq_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/deq_if.sv
// Handshake interfaces for the request and result channels of the queue.
// Depends on deq_pkg for the field widths.
`default_nettype none
interface deq_in_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::CMD_W-1:0]   command;
  logic [deq_pkg::WORD_W-1:0]  data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface deq_out_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::WORD_W-1:0]  data_out;
  logic [deq_pkg::STAT_W-1:0]  status;
  logic                        is_empty;
  logic [deq_pkg::FILL_W-1:0]  fill_count;

  modport source (output valid, output data_out, output status, output is_empty,
                  output fill_count, input ready);
  modport sink   (input valid, input data_out, input status, input is_empty,
                  input fill_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/deq_ctrl.sv
// Controller state machine of the queue: request acceptance and result handoff.
// Depends on deq_pkg for the command type.
`default_nettype none
module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output deq_pkg::deq_ctrl_t     ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    ctrl.exec     = 1'b0;
    ctrl.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.exec = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        // The read data is ready now; hand it over once the result slot frees.
        if (!out_valid_r || out_ready) begin
          ctrl.load_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: hw/rtl/deq_datapath.sv
// Datapath of the queue: ring-buffer store, front and back indices, entry count
// and the result register. Depends on deq_pkg for codes, widths and types.
`default_nettype none
module deq_datapath #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire deq_pkg::deq_ctrl_t          ctrl,
  input  wire logic [deq_pkg::CMD_W-1:0]   command,
  input  wire logic [deq_pkg::WORD_W-1:0]  data_in,
  output logic [deq_pkg::WORD_W-1:0]       data_out,
  output logic [deq_pkg::STAT_W-1:0]       status,
  output logic                             is_empty,
  output logic [deq_pkg::FILL_W-1:0]       fill_count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Only the low MEM_W bits of a word are stored: DATA_WIDTH, capped at 32.
  localparam int MEM_W = (DATA_WIDTH < deq_pkg::WORD_W) ? DATA_WIDTH : deq_pkg::WORD_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [MEM_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [MEM_W-1:0]          rd_data_r;
  logic                      rd_ok_r;
  logic [deq_pkg::STAT_W-1:0] stat_r;

  logic                       wr_en, rd_en;
  logic [IDX_W-1:0]           wr_addr, rd_addr;
  logic [deq_pkg::STAT_W-1:0] stat_nxt;
  logic                       empty, full;
  logic [IDX_W-1:0]           front_next, front_prev, back_prev;

  logic [deq_pkg::WORD_W-1:0] data_out_r;
  logic [deq_pkg::STAT_W-1:0] status_r;
  logic                       is_empty_r;
  logic [deq_pkg::FILL_W-1:0] fill_count_r;

  assign empty      = (count_r == '0);
  assign full       = (count_r >= CNT_FULL);
  assign front_next = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;
  assign front_prev = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign back_prev  = (back_r == '0) ? IDX_LAST : back_r - 1'b1;

  always_comb begin
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = back_r;
    rd_addr   = front_r;
    stat_nxt  = deq_pkg::ST_OK;
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    case (command)
      deq_pkg::CMD_ADD_FRONT: begin
        if (full) begin
          stat_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = front_prev;
          front_nxt = front_prev;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::CMD_ADD_BACK: begin
        if (full) begin
          stat_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = back_r;
          back_nxt  = (back_r == IDX_LAST) ? '0 : back_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::CMD_REM_FRONT: begin
        if (empty) begin
          stat_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = front_r;
          front_nxt = front_next;
          count_nxt = count_r - 1'b1;
        end
      end
      deq_pkg::CMD_REM_BACK: begin
        if (empty) begin
          stat_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = back_prev;
          back_nxt  = back_prev;
          count_nxt = count_r - 1'b1;
        end
      end
      deq_pkg::CMD_PEEK_FRONT: begin
        if (empty) begin
          stat_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = front_r;
        end
      end
      deq_pkg::CMD_PEEK_BACK: begin
        if (empty) begin
          stat_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = back_prev;
        end
      end
      default: ;
    endcase
  end

  // Store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      mem[wr_addr] <= MEM_W'(data_in);
    end
    if (ctrl.exec && rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (ctrl.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      rd_ok_r <= rd_en;
      stat_r  <= stat_nxt;
    end
  end

  // The count register already holds the post-request value here.
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      data_out_r   <= rd_ok_r ? deq_pkg::WORD_W'(rd_data_r) : '0;
      status_r     <= stat_r;
      is_empty_r   <= empty;
      fill_count_r <= deq_pkg::FILL_W'(count_r);
    end
  end

  assign data_out   = data_out_r;
  assign status     = status_r;
  assign is_empty   = is_empty_r;
  assign fill_count = fill_count_r;

endmodule
`default_nettype wire

FILE: hw/rtl/double_ended_queue_core.sv
// Double-ended queue of DEPTH words kept as a ring buffer. Each request carries
// a command (add, remove or peek at the front or the back) and a data word, and
// gives exactly one result with the word read, a status, the empty flag and the
// fill count after the request. A request is first executed against the store,
// whose read port is registered, and then loads the result register once the
// result slot is free; a new request is taken only after the previous result
// has been loaded. Removing or peeking at an empty queue reports an empty
// error and adding to a full one reports a full error, neither changing state.
// The store is not cleared by reset; only entries that were added are ever read.
// Depends on deq_pkg, deq_if, deq_ctrl and deq_datapath.
`default_nettype none
module double_ended_queue_core #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  deq_pkg::deq_ctrl_t ctrl;
  logic               in_ready;
  logic               out_valid;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .command    (in_ch.command),
    .data_in    (in_ch.data_in),
    .data_out   (out_ch.data_out),
    .status     (out_ch.status),
    .is_empty   (out_ch.is_empty),
    .fill_count (out_ch.fill_count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
`default_nettype wire
